### rtl/core/i2cbb_pkg.sv
`timescale 1ns / 1ps
package i2cbb_pkg;

    localparam int BufDepthDef = 16;

    typedef enum logic [1:0] {
        K_TICK  = 2'd0,
        K_START = 2'd1,
        K_LOAD  = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START     = 3'd1,
        PH_ADDR      = 3'd2,
        PH_WRITE     = 3'd3,
        PH_READ      = 3'd4,
        PH_STOP      = 3'd5,
        PH_STOP_NACK = 3'd6
    } t_phase;

    // classified item between front and back
    typedef struct packed {
        t_kind      kind;
        logic [6:0] addr;
        logic       rd;
        logic [4:0] count;
        logic [7:0] wbyte;
        logic       sda;
    } t_cmd;

    localparam int CmdW = $bits(t_cmd);

    // result item fields, highest first
    typedef struct packed {
        logic       busy;
        logic       nack;
        logic       fin;
        logic       rlast;
        logic [7:0] rbyte;
        logic       rvalid;
        logic       sda_low;
        logic       scl_low;
    } t_res;

    localparam int ResW = $bits(t_res);

endpackage

### rtl/core/i2c_bitbang_master.sv
`timescale 1ns / 1ps
// Open-drain I2C master paced by tick items: every ticks_per_quarter ticks
// make one quarter SCL period. Load items fill the write buffer, a start item
// runs START, address, data and STOP. One result item per input item; the
// block takes one item per clock while its result is not stalled, set by the
// combinational sequencer behind a two-entry queue. Buffer bytes are read from
// a RAM with registered read, fetched while the previous byte slot is running.
module i2c_bitbang_master import i2cbb_pkg::*; #(
    parameter int BufDepth = BufDepthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // kind, target_address, read_mode, byte_count, write_byte, sda_sample
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_pull_low, sda_pull_low, read_valid, read_byte, read_last, finished,
    // address_nack, busy_res
    output logic [15:0] m_axis_tdata
);
    logic cv, cr;
    t_cmd cmd;
    t_res res;
    logic [CmdW-1:0] pk;

    assign pk = {s_axis_tdata[1:0], s_axis_tdata[8:2], s_axis_tdata[9],
                 s_axis_tdata[14:10], s_axis_tdata[22:15], s_axis_tdata[23]};
    assign o_cfg_ready = 1'b1;

    i2cbb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_data(pk), .o_valid(cv), .i_ready(cr), .o_cmd(cmd)
    );

    i2cbb_back #(.BufDepth(BufDepth)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_valid),
        .i_cfg_data(i_cfg_data), .i_valid(cv), .o_ready(cr), .i_cmd(cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {1'b0, res};
endmodule

### rtl/core/i2cbb_ram.sv
`timescale 1ns / 1ps
module i2cbb_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

### rtl/core/i2cbb_front.sv
`timescale 1ns / 1ps
module i2cbb_front import i2cbb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [CmdW-1:0]     i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output t_cmd                o_cmd
);
    // two-entry queue toward the sequencer
    t_cmd r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic r_rp, r_wp;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop = o_valid && i_ready;
    assign o_cmd = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rp <= 1'b0;
            r_wp <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
        end
        if (push) begin
            r_q[r_wp] <= t_cmd'(i_data);
        end
    end
endmodule

### rtl/core/i2cbb_back.sv
`timescale 1ns / 1ps
module i2cbb_back import i2cbb_pkg::*; #(
    parameter int BufDepth = BufDepthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output t_res        o_res
);
    localparam int AW = (BufDepth > 1) ? $clog2(BufDepth) : 1;
    localparam int PW = $clog2(BufDepth + 1);

    logic [15:0] r_tpq;
    t_phase r_ph, n_ph;
    logic [1:0] r_q, n_q;
    logic [15:0] r_div, n_div;
    logic [3:0] r_bit, n_bit;
    logic [7:0] r_sh, n_sh;
    logic [4:0] r_left, n_left;
    logic [PW-1:0] r_bp, n_bp, r_lp, n_lp;
    logic r_rd, n_rd, r_scl, n_scl, r_sda, n_sda;
    logic r_ov;
    t_res r_res, n_res;
    logic acc;
    logic [7:0] rdata;
    logic [AW-1:0] raddr;
    logic we;
    logic [15:0] lim;
    // read the next write byte as soon as the pointer advances, a byte slot ahead
    assign raddr = (r_bp < PW'(BufDepth)) ? r_bp[AW-1:0] : '0;

    i2cbb_ram #(.Width(8), .Depth(BufDepth)) u_buf (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_lp[AW-1:0]), .i_wdata(i_cmd.wbyte),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign o_ready = !r_ov || i_ready;
    assign acc = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_res = r_res;
    assign lim = (r_tpq == 16'd0) ? 16'd1 : r_tpq;
    assign we = acc && i_cmd.kind == K_LOAD && r_ph == PH_IDLE
        && r_lp < PW'(BufDepth);

    // sequencer: next state of one item
    always_comb begin
        logic [1:0] q;
        logic sd;
        logic bw;  // begin slot request
        q = r_q;
        sd = i_cmd.sda;
        bw = 1'b0;
        n_ph = r_ph; n_q = r_q; n_div = r_div; n_bit = r_bit; n_sh = r_sh;
        n_left = r_left; n_bp = r_bp; n_lp = r_lp; n_rd = r_rd;
        n_scl = r_scl; n_sda = r_sda;
        n_res = '0;
        case (i_cmd.kind)
            K_TICK: begin
                if (r_ph != PH_IDLE) begin
                    n_div = r_div + 16'd1;
                    if (n_div >= lim) begin
                        n_div = '0;
                        n_q = q + 2'd1;
                        case (r_ph)
                            PH_START: begin
                                if (q == 2'd1) n_sda = 1'b1;
                                if (q == 2'd3) begin
                                    n_scl = 1'b1; n_ph = PH_ADDR; n_bit = '0; bw = 1'b1;
                                end
                            end
                            PH_ADDR, PH_WRITE, PH_READ: begin
                                case (q)
                                    2'd0: n_scl = 1'b0;
                                    2'd1: begin
                                        if (r_ph == PH_READ && r_bit < 4'd8) begin
                                            n_sh = {r_sh[6:0], sd};
                                            if (r_bit == 4'd7) begin
                                                n_res.rvalid = 1'b1;
                                                n_res.rbyte = n_sh;
                                                n_res.rlast = (r_left == 5'd1);
                                            end
                                        end else if (r_ph == PH_ADDR && r_bit == 4'd8) begin
                                            n_sh = {7'd0, sd};
                                        end
                                    end
                                    2'd2: n_scl = 1'b1;
                                    default: begin
                                        if (r_bit < 4'd8) begin
                                            if (r_ph != PH_READ) n_sh = {r_sh[6:0], 1'b0};
                                            n_bit = r_bit + 4'd1;
                                            bw = 1'b1;
                                        end else if (r_ph == PH_ADDR) begin
                                            if (r_sh[0]) begin
                                                n_ph = PH_STOP_NACK; n_q = '0; n_sda = 1'b1;
                                            end else if (r_left == 5'd0) begin
                                                n_ph = PH_STOP; n_q = '0; n_sda = 1'b1;
                                            end else if (r_rd) begin
                                                n_ph = PH_READ; n_bit = '0; n_sh = '0;
                                                bw = 1'b1;
                                            end else begin
                                                n_ph = PH_WRITE; n_bit = '0;
                                                n_sh = (r_bp < PW'(BufDepth)) ? rdata : 8'd0;
                                                n_bp = r_bp + PW'(1); bw = 1'b1;
                                            end
                                        end else begin
                                            n_left = r_left - 5'd1;
                                            if (n_left == 5'd0) begin
                                                n_ph = PH_STOP; n_q = '0; n_sda = 1'b1;
                                            end else if (r_ph == PH_WRITE) begin
                                                n_bit = '0;
                                                n_sh = (r_bp < PW'(BufDepth)) ? rdata : 8'd0;
                                                n_bp = r_bp + PW'(1); bw = 1'b1;
                                            end else begin
                                                n_bit = '0; n_sh = '0; bw = 1'b1;
                                            end
                                        end
                                    end
                                endcase
                            end
                            PH_STOP, PH_STOP_NACK: begin
                                if (q == 2'd0) n_scl = 1'b0;
                                else if (q == 2'd1) n_sda = 1'b0;
                                else begin
                                    n_res.fin = 1'b1;
                                    n_res.nack = (r_ph == PH_STOP_NACK);
                                    n_ph = PH_IDLE; n_q = '0;
                                end
                            end
                            default: begin
                                n_ph = PH_IDLE; n_q = '0;
                            end
                        endcase
                        // drive SDA at the start of a bit slot
                        if (bw) begin
                            n_q = '0;
                            if (n_ph == PH_READ)
                                n_sda = (n_bit < 4'd8) ? 1'b0 : (n_left != 5'd1);
                            else
                                n_sda = (n_bit < 4'd8) ? !n_sh[7] : 1'b0;
                        end
                    end
                end
            end
            K_START: begin
                if (r_ph == PH_IDLE) begin
                    n_rd = i_cmd.rd;
                    n_left = (!i_cmd.rd && i_cmd.count > 5'(BufDepth > 31 ? 31 : BufDepth))
                        ? 5'(BufDepth > 31 ? 31 : BufDepth) : i_cmd.count;
                    n_sh = {i_cmd.addr, i_cmd.rd};
                    n_bp = '0; n_lp = '0; n_bit = '0; n_div = '0; n_q = '0;
                    n_scl = 1'b0; n_sda = 1'b0; n_ph = PH_START;
                end
            end
            K_LOAD: begin
                if (we) n_lp = r_lp + PW'(1);
            end
            default: ;
        endcase
        n_res.scl_low = n_scl;
        n_res.sda_low = n_sda;
        n_res.busy = (n_ph != PH_IDLE);
    end

    // hold state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpq <= 16'd1; r_ph <= PH_IDLE; r_q <= '0; r_div <= '0; r_bit <= '0;
            r_sh <= '0; r_left <= '0; r_bp <= '0; r_lp <= '0; r_rd <= 1'b0;
            r_scl <= 1'b0; r_sda <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) r_tpq <= i_cfg_data;
            if (acc) begin
                r_ph <= n_ph; r_q <= n_q; r_div <= n_div; r_bit <= n_bit; r_sh <= n_sh;
                r_left <= n_left; r_bp <= n_bp; r_lp <= n_lp; r_rd <= n_rd;
                r_scl <= n_scl; r_sda <= n_sda;
            end
            if (acc) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
        if (acc) r_res <= n_res;
    end
endmodule

### rtl/core/i2cbb_checker.sv
`timescale 1ns / 1ps
module i2cbb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    // no read byte data without its valid flag
    a_rbyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[10:3] == 8'd0)
        else $error("read byte without valid");
    // nack only with finished
    a_nack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[13] |-> m_axis_tdata[12])
        else $error("nack without finish");
    // finished leaves the lines released and idle
    a_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[1:0] == 2'b00
        && !m_axis_tdata[14])
        else $error("finish not idle");
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
endmodule

bind i2c_bitbang_master i2cbb_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
